// ===== rtl/plist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_CLEAR  = 2'd3
  } plist_action_t;

  // Broadcast from the control logic to every cell of the chain.
  typedef struct packed {
    logic                  ins_en;
    logic                  del_en;
    logic [POSITION_W-1:0] k;       // zero-based target index
  } plist_ctrl_t;

endpackage : plist_pkg
`default_nettype wire

// ===== rtl/plist_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// One storage cell of the list chain; shifts with its neighbors.
// ----------------------------------------------------------------------------
module plist_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire plist_pkg::plist_ctrl_t   ctrl,
  input  wire logic [DATA_WIDTH-1:0]    ins_word,
  input  wire logic [DATA_WIDTH-1:0]    left_word,
  input  wire logic [DATA_WIDTH-1:0]    right_word,
  output logic      [DATA_WIDTH-1:0]    word,
  output logic      [DATA_WIDTH-1:0]    rd_word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic                  at_k;
  logic                  past_k;

  assign at_k   = (32'(INDEX) == 32'(ctrl.k));
  assign past_k = (32'(INDEX) >  32'(ctrl.k));

  // Insert opens a gap at the target and moves later words up; delete pulls
  // the target and every later word down from the right-hand neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (at_k) begin
        word_r <= ins_word;
      end else if (past_k) begin
        word_r <= left_word;
      end
    end else if (ctrl.del_en && (at_k || past_k)) begin
      word_r <= right_word;
    end
  end

  assign word    = word_r;
  assign rd_word = at_k ? word_r : '0;

endmodule : plist_cell
`default_nettype wire

// ===== rtl/positional_list_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of data words with insert, delete, get and clear by position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one word each. For every request,
// at the accepting clock edge all cells at or beyond the target shift by one
// place together (up for an insert, down for a delete), so the cost of a
// request does not depend on its position or on the length of the list. A get
// selects the addressed cell's word through an OR tree across the row and
// captures it in the result register. The result register decouples the two
// channels, so a new request is accepted in the same cycle in which the
// previous result transfers; sustained throughput is one request per cycle
// while out_ready stays high. Positions are 1-based. A position of zero, a
// position past the end, or an insert into a full list is rejected with ok low
// and leaves the list unchanged. Clear always succeeds. Cell contents are not
// reset; only the entry count and the result valid flag are.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY   = plist_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [plist_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [plist_pkg::POSITION_W-1:0]   in_position,
  input  wire logic [plist_pkg::VALUE_W-1:0]      in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_ok,
  output logic      [plist_pkg::VALUE_W-1:0]      out_read_value,
  output logic      [plist_pkg::COUNT_W-1:0]      out_count,
  output logic                                    out_is_empty
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = plist_pkg::VALUE_W;
  localparam int unsigned OW = plist_pkg::COUNT_W;

  logic                     accept;
  plist_pkg::plist_action_t action;
  logic [31:0]              pos32;
  logic [31:0]              cnt32;
  logic                     pos_nz;
  logic                     in_range;
  logic                     ins_ok;
  logic                     res_ok;
  logic                     rd_sel;
  plist_pkg::plist_ctrl_t   ctrl;

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     out_ok_r;
  logic [VW-1:0]            out_read_value_r;
  logic [OW-1:0]            out_count_r;
  logic                     out_is_empty_r;

  logic [DATA_WIDTH-1:0]    ins_word;
  logic [DATA_WIDTH+VW-1:0] ins_ext;
  logic [DATA_WIDTH-1:0]    rd_or;
  logic [DATA_WIDTH+VW-1:0] rd_ext;
  logic [CW+OW-1:0]         cnt_ext;

  logic [DATA_WIDTH-1:0]    cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0]    cell_rd   [CAPACITY];

  // The result register is free when empty or when its result transfers now.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign action   = plist_pkg::plist_action_t'(in_action);

  assign pos32    = 32'(in_position);
  assign cnt32    = 32'(count_r);
  assign pos_nz   = (in_position != '0);
  assign in_range = pos_nz && (pos32 <= cnt32);
  assign ins_ok   = pos_nz && (pos32 <= cnt32 + 32'd1) && (cnt32 < 32'(CAPACITY));

  // Stored words keep the low bits of the 32-bit input value.
  assign ins_ext  = {{DATA_WIDTH{1'b0}}, in_value};
  assign ins_word = ins_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctrl.ins_en = 1'b0;
    ctrl.del_en = 1'b0;
    ctrl.k      = in_position - plist_pkg::POSITION_W'(1);
    count_nxt   = count_r;
    res_ok      = 1'b0;
    rd_sel      = 1'b0;
    case (action)
      plist_pkg::ACT_INSERT: begin
        res_ok      = ins_ok;
        ctrl.ins_en = accept && ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      plist_pkg::ACT_DELETE: begin
        res_ok      = in_range;
        ctrl.del_en = accept && in_range;
        if (in_range) begin
          count_nxt = count_r - CW'(1);
        end
      end
      plist_pkg::ACT_GET: begin
        res_ok = in_range;
        rd_sel = in_range;
      end
      plist_pkg::ACT_CLEAR: begin
        res_ok    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Row of cells; each sees its left and right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = ins_word;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    plist_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_word   (ins_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so an OR merges the row.
  always_comb begin
    rd_or = '0;
    for (int unsigned j = 0; j < CAPACITY; j++) begin
      rd_or = rd_or | cell_rd[j];
    end
  end

  assign rd_ext  = {{VW{1'b0}}, rd_or};
  assign cnt_ext = {{OW{1'b0}}, count_nxt};

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r         <= res_ok;
      out_read_value_r <= rd_sel ? rd_ext[VW-1:0] : '0;
      out_count_r      <= cnt_ext[OW-1:0];
      out_is_empty_r   <= (count_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_is_empty_r;

  // The entry count never exceeds the capacity of the row.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // An insert into a full list leaves the count unchanged.
  a_full_insert : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (action == plist_pkg::ACT_INSERT) && (count_r == CW'(CAPACITY))
    |=> (count_r == $past(count_r)) && !out_ok)
    else $error("insert into full list was not rejected");

  // A clear always reports success and an empty list.
  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (action == plist_pkg::ACT_CLEAR)
    |=> out_valid && out_ok && out_is_empty && (count_r == '0))
    else $error("clear did not empty the list");

  // Every accepted request yields a pending result in the next cycle.
  a_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // A rejected request never changes the entry count.
  a_reject_hold : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !res_ok |=> count_r == $past(count_r))
    else $error("rejected request changed the list");

endmodule : positional_list_engine_unit
`default_nettype wire
